/* sv/iks_pkg.sv */
package iks_pkg;

  typedef enum logic [2:0] {
    KM_IDLE    = 3'd0,
    KM_DIT     = 3'd1,
    KM_DAH     = 3'd2,
    KM_DIT_GAP = 3'd3,
    KM_DAH_GAP = 3'd4
  } keyer_mode_t;

  typedef enum logic [2:0] {
    SQ_IDLE    = 3'd0,
    SQ_MUTE    = 3'd1,
    SQ_RELAY   = 3'd2,
    SQ_KEYED   = 3'd3,
    SQ_TAIL    = 3'd4,
    SQ_DECAY   = 3'd5,
    SQ_UNRELAY = 3'd6,
    SQ_UNMUTE  = 3'd7
  } seq_mode_t;

  // tx sits in the lowest bit
  typedef struct packed {
    logic tone;
    logic relay;
    logic mute;
    logic tx;
  } pins_t;

  typedef enum logic [3:0] {
    REG_START_SPEED = 4'd0,
    REG_MUTE_DELAY  = 4'd1,
    REG_RELAY_DELAY = 4'd2,
    REG_DECAY_DELAY = 4'd3
  } cfg_reg_t;

  localparam logic [5:0] SPEED_MIN       = 6'd5;
  localparam logic [5:0] SPEED_MAX       = 6'd60;
  localparam logic [5:0] START_SPEED_RST = 6'd20;
  localparam logic [7:0] MUTE_DELAY_RST  = 8'd4;
  localparam logic [7:0] RELAY_DELAY_RST = 8'd31;
  localparam logic [7:0] DECAY_DELAY_RST = 8'd39;

  localparam logic [15:0] SAVE_TICKS = 16'd32760;
  localparam logic [15:0] SAVE_IDLE  = 16'hFFFF;

  // encoder fires after a high sample followed by a run of ENC_LOW_RUN low samples
  localparam int          ENC_LOW_RUN  = 12;
  localparam logic [15:0] ENC_RUN_MASK = 16'((32'd1 << (ENC_LOW_RUN + 1)) - 32'd1);
  localparam logic [15:0] ENC_FORCED   = ~ENC_RUN_MASK;
  localparam logic [15:0] ENC_TARGET   = ENC_FORCED | 16'(32'd1 << ENC_LOW_RUN);

  // dot time in ticks: floor(9375 / wpm)
  localparam logic [15:0] DOT_TICKS [64] = '{
    16'd1875, 16'd1875, 16'd1875, 16'd1875, 16'd1875, 16'd1875, 16'd1562, 16'd1339,
    16'd1171, 16'd1041, 16'd937,  16'd852,  16'd781,  16'd721,  16'd669,  16'd625,
    16'd585,  16'd551,  16'd520,  16'd493,  16'd468,  16'd446,  16'd426,  16'd407,
    16'd390,  16'd375,  16'd360,  16'd347,  16'd334,  16'd323,  16'd312,  16'd302,
    16'd292,  16'd284,  16'd275,  16'd267,  16'd260,  16'd253,  16'd246,  16'd240,
    16'd234,  16'd228,  16'd223,  16'd218,  16'd213,  16'd208,  16'd203,  16'd199,
    16'd195,  16'd191,  16'd187,  16'd183,  16'd180,  16'd176,  16'd173,  16'd170,
    16'd167,  16'd164,  16'd161,  16'd158,  16'd156,  16'd156,  16'd156,  16'd156
  };

  // floor(dot time / 3), used for the late dit-memory window
  localparam logic [15:0] DOT_THIRD [64] = '{
    16'd625,  16'd625,  16'd625,  16'd625,  16'd625,  16'd625,  16'd520,  16'd446,
    16'd390,  16'd347,  16'd312,  16'd284,  16'd260,  16'd240,  16'd223,  16'd208,
    16'd195,  16'd183,  16'd173,  16'd164,  16'd156,  16'd148,  16'd142,  16'd135,
    16'd130,  16'd125,  16'd120,  16'd115,  16'd111,  16'd107,  16'd104,  16'd100,
    16'd97,   16'd94,   16'd91,   16'd89,   16'd86,   16'd84,   16'd82,   16'd80,
    16'd78,   16'd76,   16'd74,   16'd72,   16'd71,   16'd69,   16'd67,   16'd66,
    16'd65,   16'd63,   16'd62,   16'd61,   16'd60,   16'd58,   16'd57,   16'd56,
    16'd55,   16'd54,   16'd53,   16'd52,   16'd52,   16'd52,   16'd52,   16'd52
  };

  function automatic logic [5:0] clamp_speed(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v < SPEED_MIN) r = SPEED_MIN;
    if (v > SPEED_MAX) r = SPEED_MAX;
    return r;
  endfunction

endpackage

/* sv/iambic_keyer_sequencer.sv */
// Channel  Dir  Width  Contents
// in_      in   8      one tick: paddles and encoder levels
// out_     out  16     pin levels, speed and save strobe after the tick
// cfg_     in   4+8    register index and value, always ready
//
// One item per cycle while the result is taken: the tick sits in an input register,
// one pass of logic updates all state and fills the result register.
// Reset (rst_n low at a clock edge) sets all modes idle, pins off, speed 20.
// A stalled result holds the pipe; the input register is freed as soon as the
// result register can take the next item.
module iambic_keyer_sequencer
  import iks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] dit_paddle [1] dah_paddle [2] enc_a [3] enc_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] tx_key [1] rx_mute [2] antenna_relay
                                  // [3] sidetone_on [9:4] speed_wpm [10] save_strobe
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_valid_r;
  logic [3:0]  in_data_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        adv;

  logic [7:0]  mute_delay_r, relay_delay_r, decay_delay_r;

  keyer_mode_t km_r, km_nxt;
  logic [15:0] et_r, et_nxt, et_dec;
  logic        dit_mem_r, dit_mem_nxt;
  logic        dah_mem_r, dah_mem_nxt;
  logic        key_r, key_nxt;
  seq_mode_t   sq_r, sq_nxt;
  logic [7:0]  st_r, st_nxt, st_dec;
  pins_t       pins_r, pins_nxt;
  logic [15:0] enc_hist_r, enc_hist_nxt;
  logic [5:0]  speed_r, speed_nxt;
  logic [15:0] sc_r, sc_nxt, sc_mid;
  logic        strobe;

  logic        dit_in, dah_in, enc_a_in, enc_b_in;
  logic [15:0] dot, dot_third, half, dah_len;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign dit_in   = in_data_r[0];
  assign dah_in   = in_data_r[1];
  assign enc_a_in = in_data_r[2];
  assign enc_b_in = in_data_r[3];

  assign dot       = DOT_TICKS[speed_r];
  assign dot_third = DOT_THIRD[speed_r];
  assign half      = {1'b0, dot[15:1]};
  assign dah_len   = dot + {dot[14:0], 1'b0};

  always_comb begin
    // keyer
    et_dec = et_r - 16'd1;
    et_nxt = et_dec;
    km_nxt = km_r;
    key_nxt = key_r;
    unique case (km_r)
      KM_DIT: begin
        key_nxt = 1'b1;
        if (et_dec == 16'd0) begin
          et_nxt = dot;
          km_nxt = KM_DIT_GAP;
        end
      end
      KM_DAH: begin
        key_nxt = 1'b1;
        if (et_dec == 16'd0) begin
          et_nxt = dot;
          km_nxt = KM_DAH_GAP;
        end
      end
      KM_DIT_GAP: begin
        key_nxt = 1'b0;
        if (et_dec == 16'd0) begin
          if (dah_mem_r) begin
            et_nxt = dah_len;
            km_nxt = KM_DAH;
          end else begin
            km_nxt = KM_IDLE;
          end
        end
      end
      KM_DAH_GAP: begin
        key_nxt = 1'b0;
        if (et_dec == 16'd0) begin
          if (dit_mem_r) begin
            et_nxt = dot;
            km_nxt = KM_DIT;
          end else begin
            km_nxt = KM_IDLE;
          end
        end
      end
      default: begin
        km_nxt = KM_IDLE;
        key_nxt = 1'b0;
        if (dit_in) begin
          et_nxt = dot;
          km_nxt = KM_DIT;
        end else if (dah_in) begin
          et_nxt = dah_len;
          km_nxt = KM_DAH;
        end
      end
    endcase

    // paddle memories look at the mode and timer after this tick
    dit_mem_nxt = dit_mem_r;
    if (!dit_mem_r) begin
      if (dit_in && ((km_nxt == KM_DAH && et_nxt < dot_third) ||
                     (km_nxt == KM_DAH_GAP && et_nxt > half)))
        dit_mem_nxt = 1'b1;
    end else if (km_nxt == KM_DIT) begin
      dit_mem_nxt = 1'b0;
    end

    dah_mem_nxt = dah_mem_r;
    if (!dah_mem_r) begin
      if (dah_in && ((km_nxt == KM_DIT && et_nxt < half) ||
                     (km_nxt == KM_DIT_GAP && et_nxt > half)))
        dah_mem_nxt = 1'b1;
    end else if (km_nxt == KM_DAH) begin
      dah_mem_nxt = 1'b0;
    end

    // transmit/receive sequencer
    st_dec = st_r - 8'd1;
    st_nxt = st_dec;
    sq_nxt = sq_r;
    pins_nxt = pins_r;
    unique case (sq_r)
      SQ_IDLE: begin
        if (key_nxt) begin
          st_nxt = mute_delay_r;
          sq_nxt = SQ_MUTE;
        end
      end
      SQ_MUTE: begin
        pins_nxt.mute = 1'b1;
        if (st_dec == 8'd0) begin
          st_nxt = relay_delay_r;
          sq_nxt = SQ_RELAY;
        end
      end
      SQ_RELAY: begin
        pins_nxt.relay = 1'b1;
        if (st_dec == 8'd0) sq_nxt = SQ_KEYED;
      end
      SQ_KEYED: begin
        if (!key_nxt) begin
          st_nxt = mute_delay_r + relay_delay_r + 8'd1;
          sq_nxt = SQ_TAIL;
        end else begin
          pins_nxt.tx = 1'b1;
          pins_nxt.tone = 1'b1;
        end
      end
      SQ_TAIL: begin
        if (st_dec == 8'd0) begin
          st_nxt = decay_delay_r;
          sq_nxt = SQ_DECAY;
        end
      end
      SQ_DECAY: begin
        pins_nxt.tx = 1'b0;
        pins_nxt.tone = 1'b0;
        if (st_dec == 8'd0) begin
          st_nxt = mute_delay_r;
          sq_nxt = SQ_UNRELAY;
        end
      end
      SQ_UNRELAY: begin
        pins_nxt.relay = 1'b0;
        if (st_dec == 8'd0) sq_nxt = SQ_UNMUTE;
      end
      default: begin
        pins_nxt.mute = 1'b0;
        sq_nxt = SQ_IDLE;
      end
    endcase

    // encoder: a high sample on A then a long low run is one detent
    enc_hist_nxt = {enc_hist_r[14:0], 1'b0} | {15'd0, enc_a_in} | ENC_FORCED;
    speed_nxt = speed_r;
    sc_mid = sc_r;
    if (enc_hist_nxt == ENC_TARGET) begin
      if (enc_b_in) begin
        speed_nxt = (speed_r < SPEED_MAX) ? speed_r + 6'd1 : SPEED_MAX;
      end else begin
        speed_nxt = (speed_r > SPEED_MIN) ? speed_r - 6'd1 : SPEED_MIN;
      end
      sc_mid = SAVE_TICKS;
    end

    // countdown: positive counts down, zero strobes, negative holds
    strobe = 1'b0;
    sc_nxt = sc_mid;
    if (sc_mid == 16'd0) begin
      strobe = 1'b1;
      sc_nxt = SAVE_IDLE;
    end else if (!sc_mid[15]) begin
      sc_nxt = sc_mid - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mute_delay_r <= MUTE_DELAY_RST;
      relay_delay_r <= RELAY_DELAY_RST;
      decay_delay_r <= DECAY_DELAY_RST;
      km_r <= KM_IDLE;
      et_r <= 16'd0;
      dit_mem_r <= 1'b0;
      dah_mem_r <= 1'b0;
      key_r <= 1'b0;
      sq_r <= SQ_IDLE;
      st_r <= 8'd0;
      pins_r <= '0;
      enc_hist_r <= 16'd0;
      speed_r <= clamp_speed(START_SPEED_RST);
      sc_r <= SAVE_IDLE;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (adv) begin
        km_r <= km_nxt;
        et_r <= et_nxt;
        dit_mem_r <= dit_mem_nxt;
        dah_mem_r <= dah_mem_nxt;
        key_r <= key_nxt;
        sq_r <= sq_nxt;
        st_r <= st_nxt;
        pins_r <= pins_nxt;
        enc_hist_r <= enc_hist_nxt;
        sc_r <= sc_nxt;
      end

      // a start speed write loads the running speed
      if (cfg_valid && cfg_ready && cfg_index == REG_START_SPEED) begin
        speed_r <= clamp_speed(cfg_data[5:0]);
      end else if (adv) begin
        speed_r <= speed_nxt;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MUTE_DELAY:  mute_delay_r <= cfg_data;
          REG_RELAY_DELAY: relay_delay_r <= cfg_data;
          REG_DECAY_DELAY: decay_delay_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata[3:0];
    if (adv) out_data_r <= {5'd0, strobe, speed_nxt, pins_nxt};
  end

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r >= SPEED_MIN && speed_r <= SPEED_MAX)
    else $error("speed left its range");

  a_tx_needs_relay: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r.tx |-> (pins_r.relay && pins_r.mute))
    else $error("transmitter keyed without relay and mute");

  a_dit_mem_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (km_r == KM_DIT) |-> !dit_mem_r)
    else $error("dit memory held while sending a dit");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && strobe) |=> (sc_r == SAVE_IDLE))
    else $error("save countdown not idle after strobe");

endmodule
